// ----- rtl/shr_pkg.sv -----
// Package for the stereo Hermite resampler: widths, constants, state codes
// and the control/status structs shared by the top level and the Horner unit.
// Depends on nothing.
`default_nettype none
package shr_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int PHASE_W  = FRAC_BITS + 2;
   localparam int STEP_W   = FRAC_BITS + 1;
   localparam int MU_W     = FRAC_BITS + 1;
   localparam int BIT_W    = $clog2(MU_W);
   localparam int COEF_W   = SAMPLE_BITS + 4;
   localparam int ACC_W    = SAMPLE_BITS + 3 * FRAC_BITS + 8;
   localparam int SHIFT_OUT = 3 * FRAC_BITS + 1;
   localparam int Q_W      = ACC_W - SHIFT_OUT;

   localparam int OUT_MAX  = 16;
   localparam int CNT_W    = $clog2(OUT_MAX + 1);

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
   localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << FRAC_BITS;

   // APB register map
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic [ADDR_W-1:0] ADDR_PHASE_STEP = ADDR_W'(0);

   // Horner stage codes: which term is added after each multiply by mu
   localparam logic [1:0] STG_C2 = 2'd0;
   localparam logic [1:0] STG_C1 = 2'd1;
   localparam logic [1:0] STG_X1 = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EVAL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic            start;
      logic [MU_W-1:0] mu;
   } hm_ctl_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] y;
   } hm_sts_type;

endpackage
`default_nettype wire

// ----- rtl/shr_req_if.sv -----
// Request channel: one stereo input frame with valid/ready handshake.
// Depends on shr_pkg.
`default_nettype none
interface shr_req_if;
   import shr_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_left;
   logic signed [SAMPLE_BITS-1:0] in_right;
   modport source (output valid, in_left, in_right, input ready);
   modport sink (input valid, in_left, in_right, output ready);
endinterface
`default_nettype wire

// ----- rtl/shr_rsp_if.sv -----
// Result channel: one interpolated stereo frame plus end-of-run flag.
// Depends on shr_pkg.
`default_nettype none
interface shr_rsp_if;
   import shr_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   logic                          last_of_run;
   modport source (output valid, out_left, out_right, last_of_run, input ready);
   modport sink (input valid, out_left, out_right, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/shr_horner.sv -----
// One channel of cubic Hermite evaluation in Horner form; each multiply by mu
// runs bit-serially, one bit of mu per cycle. Depends on shr_pkg.
`default_nettype none
module shr_horner (
   input  logic                                   clock,
   input  logic                                   reset,
   input  shr_pkg::hm_ctl_type                    ctl,
   input  logic signed [shr_pkg::SAMPLE_BITS-1:0] x0,
   input  logic signed [shr_pkg::SAMPLE_BITS-1:0] x1,
   input  logic signed [shr_pkg::SAMPLE_BITS-1:0] x2,
   input  logic signed [shr_pkg::SAMPLE_BITS-1:0] x3,
   output shr_pkg::hm_sts_type                    sts
);
   import shr_pkg::*;

   localparam logic signed [ACC_W-1:0] RND_BIAS = (ACC_W'(1) <<< SHIFT_OUT) - ACC_W'(1);
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

   logic signed [COEF_W-1:0] e0, e1, e2, e3, c1, c2, c3;
   logic signed [ACC_W-1:0]  add_sel, prod_next, rnd;
   logic signed [Q_W-1:0]    q;
   logic signed [SAMPLE_BITS-1:0] sat;

   logic                    run_ff, run_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic [1:0]              stage_ff, stage_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic [MU_W-1:0]         mu_ff, mu_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;

   // Catmull-Rom coefficients, times two
   always_comb begin
      e0 = COEF_W'(x0);
      e1 = COEF_W'(x1);
      e2 = COEF_W'(x2);
      e3 = COEF_W'(x3);
      c1 = e2 - e0;
      c2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      c3 = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
   end

   // Term added after each multiply
   always_comb begin
      unique case (stage_ff)
         STG_C2:  add_sel = ACC_W'(c2) <<< FRAC_BITS;
         STG_C1:  add_sel = ACC_W'(c1) <<< (2 * FRAC_BITS);
         default: add_sel = ACC_W'(x1) <<< SHIFT_OUT;
      endcase
   end

   // Shift-add step over mu, MSB first
   assign prod_next = (prod_ff <<< 1) + (mu_ff[bit_ff] ? acc_ff : '0);

   // Truncate toward zero, then saturate
   always_comb begin
      rnd = acc_ff + (acc_ff[ACC_W-1] ? RND_BIAS : '0);
      q   = Q_W'(rnd >>> SHIFT_OUT);
      if (q > Q_MAX) begin
         sat = SAMPLE_BITS'(Q_MAX);
      end else if (q < Q_MIN) begin
         sat = SAMPLE_BITS'(Q_MIN);
      end else begin
         sat = SAMPLE_BITS'(q);
      end
   end

   // Sequencing of stages and bits
   always_comb begin
      run_in   = run_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      stage_in = stage_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      mu_in    = mu_ff;
      y_in     = y_ff;
      if (ctl.start) begin
         run_in   = 1'b1;
         stage_in = STG_C2;
         bit_in   = BIT_W'(MU_W - 1);
         acc_in   = ACC_W'(c3);
         prod_in  = '0;
         mu_in    = ctl.mu;
      end else if (run_ff) begin
         if (bit_ff == '0) begin
            acc_in  = prod_next + add_sel;
            prod_in = '0;
            bit_in  = BIT_W'(MU_W - 1);
            if (stage_ff == STG_X1) begin
               run_in = 1'b0;
               fin_in = 1'b1;
            end else begin
               stage_in = stage_ff + 2'd1;
            end
         end else begin
            prod_in = prod_next;
            bit_in  = bit_ff - BIT_W'(1);
         end
      end else if (fin_ff) begin
         y_in    = sat;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      stage_ff <= stage_in;
      bit_ff   <= bit_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      mu_ff    <= mu_in;
      y_ff     <= y_in;
   end

   assign sts.done = done_ff;
   assign sts.y    = y_ff;

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(run_ff && fin_ff)) else $error("run and finish overlap");
   a_fin_after_run: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> $past(run_ff)) else $error("finish without run");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fin_ff)) else $error("done without finish");

endmodule
`default_nettype wire

// ----- rtl/stereo_hermite_resampler.sv -----
// Stereo cubic Hermite resampler. An evaluation runs the bit-serial multiply by
// mu, 17 bits, three times; each result frame then waits for the output
// handshake, and an input with no result goes straight back to idle. One
// request is in work at a time.
// Synchronous active-high reset: history zero, phase 1.0, step 1.0.
`default_nettype none
module stereo_hermite_resampler (
   input  logic                          clock,
   input  logic                          reset,
   shr_req_if.sink                       req_ch,
   shr_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [shr_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [shr_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [shr_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import shr_pkg::*;

   state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PHASE_W-1:0] phase_ff, phase_in, phase_sum;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic signed [SAMPLE_BITS-1:0] hl_ff [4];
   logic signed [SAMPLE_BITS-1:0] hr_ff [4];
   logic signed [SAMPLE_BITS-1:0] nl_ff, nr_ff;
   logic signed [SAMPLE_BITS-1:0] ol_ff, ol_in, or_ff, or_in;
   logic last_ff, last_in;
   logic shift_en, load_req, csr_wr;
   hm_ctl_type ctl;
   hm_sts_type sts_l, sts_r;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign step_in = (csr_wr && csr_paddr[ADDR_W-1:2] == ADDR_PHASE_STEP[ADDR_W-1:2]) ?
                    csr_pwdata[STEP_W-1:0] : step_ff;
   assign csr_prdata = (csr_paddr[ADDR_W-1:2] == ADDR_PHASE_STEP[ADDR_W-1:2]) ?
                       DATA_W'(step_ff) : '0;

   assign phase_sum = phase_ff + PHASE_W'(step_ff);

   // Control sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      ol_in        = ol_ff;
      or_in        = or_ff;
      last_in      = last_ff;
      shift_en     = 1'b0;
      load_req     = 1'b0;
      ctl.start    = 1'b0;
      ctl.mu       = phase_ff[MU_W-1:0];
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               load_req = 1'b1;
               n_in     = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (phase_ff <= PHASE_ONE && n_ff < CNT_W'(OUT_MAX)) begin
               ctl.start = 1'b1;
               state_in  = ST_EVAL;
            end else begin
               // drop out of the run: shift history and lower phase
               shift_en = 1'b1;
               phase_in = (phase_ff > PHASE_ONE) ? phase_ff - PHASE_ONE : '0;
               state_in = ST_IDLE;
            end
         end
         ST_EVAL: begin
            if (sts_l.done) begin
               ol_in    = sts_l.y;
               or_in    = sts_r.y;
               last_in  = (n_ff == CNT_W'(OUT_MAX - 1)) || (phase_sum > PHASE_ONE);
               phase_in = phase_sum;
               n_in     = n_ff + CNT_W'(1);
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_RESET;
         phase_ff <= PHASE_ONE;
         n_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            hl_ff[i] <= '0;
            hr_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         n_ff     <= n_in;
         if (shift_en) begin
            for (int i = 0; i < 3; i++) begin
               hl_ff[i] <= hl_ff[i+1];
               hr_ff[i] <= hr_ff[i+1];
            end
            hl_ff[3] <= nl_ff;
            hr_ff[3] <= nr_ff;
         end
      end
      if (load_req) begin
         nl_ff <= req_ch.in_left;
         nr_ff <= req_ch.in_right;
      end
      ol_ff   <= ol_in;
      or_ff   <= or_in;
      last_ff <= last_in;
   end

   assign rsp_ch.out_left    = ol_ff;
   assign rsp_ch.out_right   = or_ff;
   assign rsp_ch.last_of_run = last_ff;

   shr_horner u_left (
      .clock (clock), .reset (reset), .ctl (ctl),
      .x0 (hl_ff[0]), .x1 (hl_ff[1]), .x2 (hl_ff[2]), .x3 (hl_ff[3]),
      .sts (sts_l)
   );

   shr_horner u_right (
      .clock (clock), .reset (reset), .ctl (ctl),
      .x0 (hr_ff[0]), .x1 (hr_ff[1]), .x2 (hr_ff[2]), .x3 (hr_ff[3]),
      .sts (sts_r)
   );

   a_eval_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (phase_ff <= PHASE_ONE)) else $error("eval past 1.0");
   a_count: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(OUT_MAX)) else $error("too many results");
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      sts_l.done == sts_r.done) else $error("channel units out of step");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_of_run) |=> ##1 (state_ff == ST_IDLE))
      else $error("run did not end after last");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for the stereo Hermite resampler: random and table-driven
// stereo frames against a bit-exact interpolator, with APB rate programming.
// Depends on shr_pkg, shr_req_if, shr_rsp_if and stereo_hermite_resampler.
`default_nettype none
module testbench;
   import shr_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
      logic       last;
   } frame_type;

   typedef struct {
      sample_type in_l;
      sample_type in_r;
      sample_type exp_l;
      sample_type exp_r;
   } table_row_type;

   localparam int ADDR_SPARE = 4;   // byte address of a register that does not exist
   localparam int DRAIN_CYCLES = 120;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   shr_req_if req_ch ();
   shr_rsp_if rsp_ch ();

   stereo_hermite_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // interpolator state mirrored from the block
   sample_type         hist_l [4];
   sample_type         hist_r [4];
   logic [PHASE_W-1:0] cur_phase;
   logic [STEP_W-1:0]  cur_step;

   frame_type pending_frames[$];
   int        failures;
   bit        no_idle;
   bit        long_hold;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // exact Catmull-Rom value at mu, truncated toward zero and saturated
   function automatic sample_type hermite(input sample_type x0, input sample_type x1,
                                          input sample_type x2, input sample_type x3,
                                          input logic [PHASE_W-1:0] mu);
      logic signed [127:0] c1, c2, c3, base, p, acc;
      logic [127:0] mag;
      logic neg;
      c1 = x2 - x0;
      c2 = 2 * x0 - 5 * x1 + 4 * x2 - x3;
      c3 = -x0 + 3 * x1 - 3 * x2 + x3;
      base = x1;
      p = {110'd0, mu};
      acc = c3 * p + (c2 <<< FRAC_BITS);
      acc = acc * p + (c1 <<< (2 * FRAC_BITS));
      acc = acc * p + (base <<< SHIFT_OUT);
      neg = acc[127];
      mag = neg ? -acc : acc;
      mag = mag >> SHIFT_OUT;
      if (neg) return (mag > 32768) ? sample_type'(-32768) : sample_type'(-mag);
      return (mag > 32767) ? sample_type'(32767) : sample_type'(mag);
   endfunction

   // advance the mirrored state by one request and collect its output frames
   task automatic resample(input sample_type in_l, input sample_type in_r,
                           ref frame_type frames[$]);
      int n;
      frame_type f;
      n = 0;
      while (n < OUT_MAX && cur_phase <= PHASE_ONE) begin
         f.left  = hermite(hist_l[0], hist_l[1], hist_l[2], hist_l[3], cur_phase);
         f.right = hermite(hist_r[0], hist_r[1], hist_r[2], hist_r[3], cur_phase);
         f.last  = 1'b0;
         frames.push_back(f);
         cur_phase = cur_phase + PHASE_W'(cur_step);
         n++;
      end
      if (n > 0) frames[$].last = 1'b1;
      for (int i = 0; i < 3; i++) begin
         hist_l[i] = hist_l[i + 1];
         hist_r[i] = hist_r[i + 1];
      end
      hist_l[3] = in_l;
      hist_r[3] = in_r;
      cur_phase = (cur_phase > PHASE_ONE) ? cur_phase - PHASE_ONE : '0;
   endtask

   // offer one request, hold until accepted, then queue its frames
   task automatic send_frame(input sample_type l, input sample_type r, input bit typed,
                             input sample_type exp_l, input sample_type exp_r);
      frame_type frames[$];
      frame_type f;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.in_left  <= l;
      req_ch.in_right <= r;
      do @(posedge clock); while (!req_ch.ready);
      resample(l, r, frames);
      if (typed) begin
         f.left = exp_l;
         f.right = exp_r;
         f.last = 1'b1;
         frames = '{f};
      end
      foreach (frames[i]) pending_frames.push_back(frames[i]);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB access: setup, then access; pready is always high
   task automatic csr_access(input bit wr, input int addr, input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_W'(addr);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_step(input int addr, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] rd;
      csr_access(1'b1, addr, value, rd);
      if (addr == int'(ADDR_PHASE_STEP)) cur_step = value[STEP_W-1:0];
      csr_access(1'b0, int'(ADDR_PHASE_STEP), '0, rd);
      if (rd[STEP_W-1:0] !== cur_step) begin
         $error("phase_step: expected %0d, actual %0d", cur_step, rd[STEP_W-1:0]);
         failures++;
      end
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // random frames; pause midway until every pending frame has arrived
   task automatic random_frames(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained();
         send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
      wait_drained();
   endtask

   // compare each result with the oldest pending frame
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: out_left %0d out_right %0d",
                   rsp_ch.out_left, rsp_ch.out_right);
            failures++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_ch.out_left !== want.left) begin
               $error("out_left: expected %0d, actual %0d", want.left, rsp_ch.out_left);
               failures++;
            end
            if (rsp_ch.out_right !== want.right) begin
               $error("out_right: expected %0d, actual %0d", want.right, rsp_ch.out_right);
               failures++;
            end
            if (rsp_ch.last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last,
                      rsp_ch.last_of_run);
               failures++;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (700) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // step 1.0 returns history entry 2, so each row expects the input two rows up
   table_row_type directed_rows[] = '{
      '{ 32767, -32768,      0,      0},
      '{-32768,  32767,      0,      0},
      '{    -1,      1,  32767, -32768},
      '{     1,     -1, -32768,  32767},
      '{ 21845, -21846,     -1,      1},
      '{     0,      0,      1,     -1},
      '{ 32767,  32767,  21845, -21846},
      '{-32768, -32768,      0,      0},
      '{ 32767, -32768,  32767,  32767},
      '{     0,      0, -32768, -32768},
      '{ 12345, -12345,  32767, -32768},
      '{     0,      0,      0,      0},
      '{     0,      0,  12345, -12345}
   };

   initial begin
      failures = 0;
      no_idle = 1'b0;
      long_hold = 1'b0;
      cur_phase = PHASE_ONE;
      cur_step = STEP_RESET;
      for (int i = 0; i < 4; i++) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
      end
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.in_left <= '0;
      req_ch.in_right <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // table at the reset rate
      foreach (directed_rows[i])
         send_frame(directed_rows[i].in_l, directed_rows[i].in_r, 1'b1,
                    directed_rows[i].exp_l, directed_rows[i].exp_r);
      wait_drained();

      // all-ones write masks to the top step; inputs often give no output
      set_step(int'(ADDR_PHASE_STEP), 32'hFFFF_FFFF);
      set_step(ADDR_SPARE, 32'h0000_1000);
      random_frames(12);

      // step 1/16, then zero and one: at most sixteen frames per request
      set_step(int'(ADDR_PHASE_STEP), 32'd4096);
      random_frames(6);
      set_step(int'(ADDR_PHASE_STEP), 32'd0);
      random_frames(3);
      set_step(int'(ADDR_PHASE_STEP), 32'd1);
      random_frames(3);

      // unit step with the receiver held off so the block backs up
      set_step(int'(ADDR_PHASE_STEP), 32'd65536);
      long_hold = 1'b1;
      random_frames(20);

      // half step reaches overshoot, then random rates, some without idling
      set_step(int'(ADDR_PHASE_STEP), 32'd32768);
      random_frames(12);
      for (int k = 0; k < 6; k++) begin
         no_idle = (k % 2 == 1);
         set_step(int'(ADDR_PHASE_STEP), $urandom_range(4096, 131071));
         random_frames(12);
      end
      no_idle = 1'b0;

      wait_drained();
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- stereo_hermite_resampler.f -----
rtl/shr_pkg.sv
rtl/shr_req_if.sv
rtl/shr_rsp_if.sv
rtl/shr_horner.sv
rtl/stereo_hermite_resampler.sv
tb/testbench.sv
